// ===== src/i2cram_pkg.sv =====
// package for the i2c register access master: phase and stage codes,
// register indexes and bus constants
// no dependencies
package i2cram_pkg;

    localparam int MAX_BYTES = 8;

    localparam logic [7:0]  DEV_ADDR_RESET   = 8'h28;
    localparam logic [9:0]  POLL_LIMIT_RESET = 10'd250;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_DEV_ADDR   = 1'b0,
        CFG_POLL_LIMIT = 1'b1
    } cfg_index_t;

    // input beat kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_SPARE = 2'd3
    } kind_t;

    // bus phase of the transfer
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_START = 4'd1,
        PH_SEND  = 4'd2,
        PH_AREL  = 4'd3,
        PH_APOLL = 4'd4,
        PH_ALOW  = 4'd5,
        PH_READ  = 4'd6,
        PH_MACK  = 4'd7,
        PH_MNACK = 4'd8,
        PH_STOP  = 4'd9
    } phase_t;

    // which byte of the transaction is on the bus
    typedef enum logic [2:0] {
        ST_DEV   = 3'd0,
        ST_RHI   = 3'd1,
        ST_RLO   = 3'd2,
        ST_RDADR = 3'd3,
        ST_DATA  = 3'd4
    } stage_t;

endpackage

// ===== src/i2c_register_access_master_core.sv =====
// top level of the i2c register access master: bus sequencer and result register
// depends on i2cram_pkg
//
// usage:
// - input channel (in_valid / in_stall) carries one beat per bus delay slot.
//   kind selects a tick slot or a register write / read command. a command
//   taken while idle latches reg_addr, byte_count and write_data; while busy
//   it is dropped. a tick beat advances the bus by one slot and samples sda_in.
// - output channel (out_valid / out_stall) returns exactly one result beat
//   per input beat: the scl and sda_out levels, busy_res, a received byte
//   with read_valid, and done_res / ack_error on the final stop slot.
// - the result of a beat is in the output register the cycle after the beat is
//   taken. one beat is taken every cycle; the only limit is the single output
//   register, which frees up as soon as the receiver takes its beat.
// - when the receiver stalls, the result holds and in_stall rises, so the
//   next input beat waits; nothing is dropped.
// - reset (rst_n low, asynchronous) returns to idle with both lines released
//   and the configuration registers at their defaults (address 0x28, poll
//   limit 250). config writes apply at once, so make them with no beat in flight
module i2c_register_access_master_core
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] reg_addr,
    input  logic [3:0]  byte_count,
    input  logic [63:0] write_data,
    input  logic        sda_in,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl,
    output logic        sda_out,
    output logic        busy_res,
    output logic        read_valid,
    output logic [7:0]  read_byte,
    output logic        done_res,
    output logic        ack_error
);

    // configuration registers
    logic [7:0] dev_addr_reg;
    logic [9:0] poll_limit_reg;

    // sequencer state
    i2cram_pkg::phase_t phase_reg, phase_next;
    i2cram_pkg::stage_t stage_reg, stage_next;
    logic [1:0]  slot_reg, slot_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [63:0] data_buffer_reg, data_buffer_next;
    logic [3:0]  length_reg, length_next;
    logic [9:0]  poll_count_reg, poll_count_next;
    logic        is_read_reg, is_read_next;
    logic [15:0] reg_hold_reg, reg_hold_next;
    logic        err_flag_reg, err_flag_next;
    logic        scl_lvl_reg, scl_lvl_next;
    logic        sda_lvl_reg, sda_lvl_next;

    // result beat
    logic        out_valid_reg;
    logic        rvalid_next;
    logic [7:0]  rbyte_next;
    logic        done_next;
    logic        aerr_next;
    logic        busy_reg;
    logic        rvalid_reg;
    logic [7:0]  rbyte_reg;
    logic        done_reg;
    logic        aerr_reg;

    logic        in_accept;
    logic [3:0]  cnt_sat;
    logic [7:0]  next_data_byte;
    logic [3:0]  byte_inc;
    logic [7:0]  shift_in;
    logic [2:0]  bit_inc;

    // output register frees when the receiver takes it
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // byte count: zero counts as one, saturate at the buffer depth
    always_comb
    begin
        if (byte_count == 4'd0)
        begin
            cnt_sat = 4'd1;
        end
        else if (byte_count > 4'(i2cram_pkg::MAX_BYTES))
        begin
            cnt_sat = 4'(i2cram_pkg::MAX_BYTES);
        end
        else
        begin
            cnt_sat = byte_count;
        end
    end

    assign byte_inc       = byte_index_reg + 4'd1;
    assign next_data_byte = data_buffer_reg[{byte_inc[2:0], 3'b000} +: 8];
    assign shift_in       = {shift_reg[6:0], sda_in};
    assign bit_inc        = bit_index_reg + 3'd1;

    // next state and result for one beat
    always_comb
    begin
        phase_next       = phase_reg;
        stage_next       = stage_reg;
        slot_next        = slot_reg;
        bit_index_next   = bit_index_reg;
        byte_index_next  = byte_index_reg;
        shift_next       = shift_reg;
        data_buffer_next = data_buffer_reg;
        length_next      = length_reg;
        poll_count_next  = poll_count_reg;
        is_read_next     = is_read_reg;
        reg_hold_next    = reg_hold_reg;
        err_flag_next    = err_flag_reg;
        scl_lvl_next     = scl_lvl_reg;
        sda_lvl_next     = sda_lvl_reg;
        rvalid_next      = 1'b0;
        rbyte_next       = 8'd0;
        done_next        = 1'b0;
        aerr_next        = 1'b0;

        if (kind == i2cram_pkg::KIND_WRITE || kind == i2cram_pkg::KIND_READ)
        begin
            // command beat: latch operands when idle, lines untouched
            if (phase_reg == i2cram_pkg::PH_IDLE)
            begin
                length_next      = cnt_sat;
                reg_hold_next    = reg_addr;
                data_buffer_next = write_data;
                is_read_next     = (kind == i2cram_pkg::KIND_READ);
                byte_index_next  = 4'd0;
                bit_index_next   = 3'd0;
                shift_next       = 8'd0;
                poll_count_next  = 10'd0;
                stage_next       = i2cram_pkg::ST_DEV;
                err_flag_next    = 1'b0;
                slot_next        = 2'd0;
                phase_next       = i2cram_pkg::PH_START;
            end
        end
        else
        begin
            case (phase_reg)
                i2cram_pkg::PH_IDLE:
                begin
                    phase_next = i2cram_pkg::PH_IDLE;
                end
                i2cram_pkg::PH_START:
                begin
                    if (slot_reg == 2'd0)
                    begin
                        scl_lvl_next = 1'b1;
                        sda_lvl_next = 1'b1;
                        slot_next    = 2'd1;
                    end
                    else if (slot_reg == 2'd1)
                    begin
                        scl_lvl_next = 1'b1;
                        sda_lvl_next = 1'b0;
                        slot_next    = 2'd2;
                    end
                    else
                    begin
                        scl_lvl_next   = 1'b0;
                        sda_lvl_next   = 1'b0;
                        shift_next     = (stage_reg == i2cram_pkg::ST_RDADR)
                                         ? (dev_addr_reg | 8'h01) : dev_addr_reg;
                        bit_index_next = 3'd0;
                        slot_next      = 2'd0;
                        phase_next     = i2cram_pkg::PH_SEND;
                    end
                end
                i2cram_pkg::PH_SEND:
                begin
                    sda_lvl_next = shift_reg[7];
                    if (slot_reg == 2'd0)
                    begin
                        scl_lvl_next = 1'b0;
                        slot_next    = 2'd1;
                    end
                    else
                    begin
                        scl_lvl_next   = 1'b1;
                        slot_next      = 2'd0;
                        shift_next     = {shift_reg[6:0], 1'b0};
                        bit_index_next = bit_inc;
                        if (bit_inc == 3'd0)
                        begin
                            phase_next = i2cram_pkg::PH_AREL;
                        end
                    end
                end
                i2cram_pkg::PH_AREL:
                begin
                    scl_lvl_next    = 1'b0;
                    sda_lvl_next    = 1'b1;
                    poll_count_next = 10'd0;
                    phase_next      = i2cram_pkg::PH_APOLL;
                end
                i2cram_pkg::PH_APOLL:
                begin
                    scl_lvl_next = 1'b1;
                    sda_lvl_next = 1'b1;
                    if (!sda_in)
                    begin
                        phase_next = i2cram_pkg::PH_ALOW;
                    end
                    else if (poll_count_reg >= poll_limit_reg)
                    begin
                        // poll timed out: stop with error
                        err_flag_next = 1'b1;
                        slot_next     = 2'd0;
                        phase_next    = i2cram_pkg::PH_STOP;
                    end
                    else
                    begin
                        poll_count_next = poll_count_reg + 10'd1;
                    end
                end
                i2cram_pkg::PH_ALOW:
                begin
                    scl_lvl_next = 1'b0;
                    sda_lvl_next = 1'b1;
                    case (stage_reg)
                        i2cram_pkg::ST_DEV:
                        begin
                            stage_next     = i2cram_pkg::ST_RHI;
                            shift_next     = reg_hold_reg[15:8];
                            bit_index_next = 3'd0;
                            slot_next      = 2'd0;
                            phase_next     = i2cram_pkg::PH_SEND;
                        end
                        i2cram_pkg::ST_RHI:
                        begin
                            stage_next     = i2cram_pkg::ST_RLO;
                            shift_next     = reg_hold_reg[7:0];
                            bit_index_next = 3'd0;
                            slot_next      = 2'd0;
                            phase_next     = i2cram_pkg::PH_SEND;
                        end
                        i2cram_pkg::ST_RLO:
                        begin
                            if (is_read_reg)
                            begin
                                // repeated start for the read address
                                stage_next = i2cram_pkg::ST_RDADR;
                                slot_next  = 2'd0;
                                phase_next = i2cram_pkg::PH_START;
                            end
                            else
                            begin
                                stage_next      = i2cram_pkg::ST_DATA;
                                byte_index_next = 4'd0;
                                shift_next      = data_buffer_reg[7:0];
                                bit_index_next  = 3'd0;
                                slot_next       = 2'd0;
                                phase_next      = i2cram_pkg::PH_SEND;
                            end
                        end
                        i2cram_pkg::ST_RDADR:
                        begin
                            stage_next      = i2cram_pkg::ST_DATA;
                            byte_index_next = 4'd0;
                            bit_index_next  = 3'd0;
                            shift_next      = 8'd0;
                            slot_next       = 2'd0;
                            phase_next      = i2cram_pkg::PH_READ;
                        end
                        default:
                        begin
                            // write data byte acknowledged
                            byte_index_next = byte_inc;
                            if (byte_inc >= length_reg)
                            begin
                                err_flag_next = 1'b0;
                                slot_next     = 2'd0;
                                phase_next    = i2cram_pkg::PH_STOP;
                            end
                            else
                            begin
                                shift_next     = next_data_byte;
                                bit_index_next = 3'd0;
                                slot_next      = 2'd0;
                                phase_next     = i2cram_pkg::PH_SEND;
                            end
                        end
                    endcase
                end
                i2cram_pkg::PH_READ:
                begin
                    sda_lvl_next = 1'b1;
                    if (slot_reg == 2'd0)
                    begin
                        scl_lvl_next = 1'b1;
                        shift_next   = shift_in;
                        if (bit_index_reg == 3'd7)
                        begin
                            rvalid_next = 1'b1;
                            rbyte_next  = shift_in;
                        end
                        slot_next = 2'd1;
                    end
                    else
                    begin
                        scl_lvl_next   = 1'b0;
                        slot_next      = 2'd0;
                        bit_index_next = bit_inc;
                        if (bit_inc == 3'd0)
                        begin
                            // last byte gets a nack
                            if ({1'b0, byte_index_reg} + 5'd1 >= {1'b0, length_reg})
                            begin
                                phase_next = i2cram_pkg::PH_MNACK;
                            end
                            else
                            begin
                                phase_next = i2cram_pkg::PH_MACK;
                            end
                        end
                    end
                end
                i2cram_pkg::PH_MACK:
                begin
                    if (slot_reg == 2'd0)
                    begin
                        scl_lvl_next = 1'b0;
                        sda_lvl_next = 1'b0;
                        slot_next    = 2'd1;
                    end
                    else if (slot_reg == 2'd1)
                    begin
                        scl_lvl_next = 1'b1;
                        sda_lvl_next = 1'b0;
                        slot_next    = 2'd2;
                    end
                    else if (slot_reg == 2'd2)
                    begin
                        scl_lvl_next = 1'b0;
                        sda_lvl_next = 1'b0;
                        slot_next    = 2'd3;
                    end
                    else
                    begin
                        scl_lvl_next    = 1'b0;
                        sda_lvl_next    = 1'b1;
                        byte_index_next = byte_inc;
                        bit_index_next  = 3'd0;
                        shift_next      = 8'd0;
                        slot_next       = 2'd0;
                        phase_next      = i2cram_pkg::PH_READ;
                    end
                end
                i2cram_pkg::PH_MNACK:
                begin
                    sda_lvl_next = 1'b1;
                    if (slot_reg == 2'd0)
                    begin
                        scl_lvl_next = 1'b0;
                        slot_next    = 2'd1;
                    end
                    else if (slot_reg == 2'd1)
                    begin
                        scl_lvl_next = 1'b1;
                        slot_next    = 2'd2;
                    end
                    else
                    begin
                        scl_lvl_next  = 1'b0;
                        err_flag_next = 1'b0;
                        slot_next     = 2'd0;
                        phase_next    = i2cram_pkg::PH_STOP;
                    end
                end
                i2cram_pkg::PH_STOP:
                begin
                    if (slot_reg == 2'd0)
                    begin
                        // scl left as is: high after a poll timeout
                        sda_lvl_next = 1'b0;
                        slot_next    = 2'd1;
                    end
                    else if (slot_reg == 2'd1)
                    begin
                        scl_lvl_next = 1'b1;
                        sda_lvl_next = 1'b0;
                        slot_next    = 2'd2;
                    end
                    else
                    begin
                        scl_lvl_next  = 1'b1;
                        sda_lvl_next  = 1'b1;
                        done_next     = 1'b1;
                        aerr_next     = err_flag_reg;
                        err_flag_next = 1'b0;
                        slot_next     = 2'd0;
                        phase_next    = i2cram_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = i2cram_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg   <= i2cram_pkg::DEV_ADDR_RESET;
            poll_limit_reg <= i2cram_pkg::POLL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cram_pkg::CFG_DEV_ADDR:   dev_addr_reg   <= cfg_data[7:0];
                i2cram_pkg::CFG_POLL_LIMIT: poll_limit_reg <= cfg_data;
                default:                    dev_addr_reg   <= dev_addr_reg;
            endcase
        end
    end

    // sequencer state, advanced once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= i2cram_pkg::PH_IDLE;
            stage_reg       <= i2cram_pkg::ST_DEV;
            slot_reg        <= 2'd0;
            bit_index_reg   <= 3'd0;
            byte_index_reg  <= 4'd0;
            shift_reg       <= 8'd0;
            data_buffer_reg <= 64'd0;
            length_reg      <= 4'd1;
            poll_count_reg  <= 10'd0;
            is_read_reg     <= 1'b0;
            reg_hold_reg    <= 16'd0;
            err_flag_reg    <= 1'b0;
            scl_lvl_reg     <= 1'b1;
            sda_lvl_reg     <= 1'b1;
        end
        else if (in_accept)
        begin
            phase_reg       <= phase_next;
            stage_reg       <= stage_next;
            slot_reg        <= slot_next;
            bit_index_reg   <= bit_index_next;
            byte_index_reg  <= byte_index_next;
            shift_reg       <= shift_next;
            data_buffer_reg <= data_buffer_next;
            length_reg      <= length_next;
            poll_count_reg  <= poll_count_next;
            is_read_reg     <= is_read_next;
            reg_hold_reg    <= reg_hold_next;
            err_flag_reg    <= err_flag_next;
            scl_lvl_reg     <= scl_lvl_next;
            sda_lvl_reg     <= sda_lvl_next;
        end
    end

    // result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            busy_reg   <= (phase_next != i2cram_pkg::PH_IDLE);
            rvalid_reg <= rvalid_next;
            rbyte_reg  <= rbyte_next;
            done_reg   <= done_next;
            aerr_reg   <= aerr_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl        = scl_lvl_reg;
    assign sda_out    = sda_lvl_reg;
    assign busy_res   = busy_reg;
    assign read_valid = rvalid_reg;
    assign read_byte  = rbyte_reg;
    assign done_res   = done_reg;
    assign ack_error  = aerr_reg;

endmodule

// ===== bench/i2c_register_access_master_core_checker.sv =====
`timescale 1ns / 100ps
// checker for the i2c register access master: follows the config port and both
// beat channels, predicts every bus slot and compares it with the result beat
// depends on i2cram_pkg
module i2c_register_access_master_core_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] reg_addr,
    input  logic [3:0]  byte_count,
    input  logic [63:0] write_data,
    input  logic        sda_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        scl,
    input  logic        sda_out,
    input  logic        busy_res,
    input  logic        read_valid,
    input  logic [7:0]  read_byte,
    input  logic        done_res,
    input  logic        ack_error,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       rvalid;
        logic [7:0] rbyte;
        logic       done;
        logic       aerr;
    } bus_slot_t;

    bus_slot_t due_slots[$];
    int        bad_beats;

    // configuration copy
    logic [7:0]  dev_addr;
    logic [9:0]  poll_limit;

    // bus sequencer copy
    i2cram_pkg::phase_t ph;
    i2cram_pkg::stage_t stg;
    logic [1:0]  slot_n;
    logic [2:0]  bit_n;
    logic [3:0]  byte_n;
    logic [7:0]  shifter;
    logic [63:0] wbuf;
    logic [3:0]  nbytes;
    logic [9:0]  polls;
    logic        rd_op;
    logic [15:0] reg_latch;
    logic        err_pend;
    logic        scl_q;
    logic        sda_q;

    function automatic void load_byte(input logic [7:0] value);
        shifter = value;
        bit_n = 3'd0;
        slot_n = 2'd0;
        ph = i2cram_pkg::PH_SEND;
    endfunction

    function automatic void stop_with(input logic err);
        err_pend = err;
        slot_n = 2'd0;
        ph = i2cram_pkg::PH_STOP;
    endfunction

    function automatic logic [7:0] data_byte();
        return wbuf[8*byte_n[2:0] +: 8];
    endfunction

    function automatic bus_slot_t predict_slot(input logic [1:0] k, input logic [15:0] ra,
        input logic [3:0] bc, input logic [63:0] wd, input logic sd);
        bus_slot_t r;
        logic [3:0] cnt;
        r = '0;
        if (k == i2cram_pkg::KIND_WRITE || k == i2cram_pkg::KIND_READ)
        begin
            // commands only land while idle
            if (ph == i2cram_pkg::PH_IDLE)
            begin
                if (bc == 4'd0)
                    cnt = 4'd1;
                else if (bc > 4'(i2cram_pkg::MAX_BYTES))
                    cnt = 4'(i2cram_pkg::MAX_BYTES);
                else
                    cnt = bc;
                nbytes = cnt;
                reg_latch = ra;
                wbuf = wd;
                rd_op = (k == i2cram_pkg::KIND_READ);
                byte_n = 4'd0;
                bit_n = 3'd0;
                shifter = 8'd0;
                polls = 10'd0;
                stg = i2cram_pkg::ST_DEV;
                err_pend = 1'b0;
                slot_n = 2'd0;
                ph = i2cram_pkg::PH_START;
            end
        end
        else
        begin
            case (ph)
                i2cram_pkg::PH_START:
                begin
                    if (slot_n == 2'd0)
                    begin
                        scl_q = 1'b1; sda_q = 1'b1; slot_n = 2'd1;
                    end
                    else if (slot_n == 2'd1)
                    begin
                        scl_q = 1'b1; sda_q = 1'b0; slot_n = 2'd2;
                    end
                    else
                    begin
                        scl_q = 1'b0; sda_q = 1'b0;
                        load_byte(stg == i2cram_pkg::ST_RDADR ? (dev_addr | 8'h01)
                                                              : dev_addr);
                    end
                end
                i2cram_pkg::PH_SEND:
                begin
                    sda_q = shifter[7];
                    if (slot_n == 2'd0)
                    begin
                        scl_q = 1'b0; slot_n = 2'd1;
                    end
                    else
                    begin
                        scl_q = 1'b1;
                        slot_n = 2'd0;
                        shifter = {shifter[6:0], 1'b0};
                        bit_n = bit_n + 3'd1;
                        if (bit_n == 3'd0)
                            ph = i2cram_pkg::PH_AREL;
                    end
                end
                i2cram_pkg::PH_AREL:
                begin
                    scl_q = 1'b0; sda_q = 1'b1;
                    polls = 10'd0;
                    ph = i2cram_pkg::PH_APOLL;
                end
                i2cram_pkg::PH_APOLL:
                begin
                    scl_q = 1'b1; sda_q = 1'b1;
                    if (!sd)
                        ph = i2cram_pkg::PH_ALOW;
                    else if (polls >= poll_limit)
                        stop_with(1'b1);
                    else
                        polls = polls + 10'd1;
                end
                i2cram_pkg::PH_ALOW:
                begin
                    scl_q = 1'b0; sda_q = 1'b1;
                    case (stg)
                        i2cram_pkg::ST_DEV:
                        begin
                            stg = i2cram_pkg::ST_RHI;
                            load_byte(reg_latch[15:8]);
                        end
                        i2cram_pkg::ST_RHI:
                        begin
                            stg = i2cram_pkg::ST_RLO;
                            load_byte(reg_latch[7:0]);
                        end
                        i2cram_pkg::ST_RLO:
                        begin
                            if (rd_op)
                            begin
                                stg = i2cram_pkg::ST_RDADR; slot_n = 2'd0;
                                ph = i2cram_pkg::PH_START;
                            end
                            else
                            begin
                                stg = i2cram_pkg::ST_DATA; byte_n = 4'd0;
                                load_byte(data_byte());
                            end
                        end
                        i2cram_pkg::ST_RDADR:
                        begin
                            stg = i2cram_pkg::ST_DATA;
                            byte_n = 4'd0; bit_n = 3'd0; shifter = 8'd0; slot_n = 2'd0;
                            ph = i2cram_pkg::PH_READ;
                        end
                        default:
                        begin
                            byte_n = byte_n + 4'd1;
                            if (byte_n >= nbytes)
                                stop_with(1'b0);
                            else
                                load_byte(data_byte());
                        end
                    endcase
                end
                i2cram_pkg::PH_READ:
                begin
                    sda_q = 1'b1;
                    if (slot_n == 2'd0)
                    begin
                        scl_q = 1'b1;
                        shifter = {shifter[6:0], sd};
                        if (bit_n == 3'd7)
                        begin
                            r.rvalid = 1'b1; r.rbyte = shifter;
                        end
                        slot_n = 2'd1;
                    end
                    else
                    begin
                        scl_q = 1'b0;
                        slot_n = 2'd0;
                        bit_n = bit_n + 3'd1;
                        if (bit_n == 3'd0)
                            ph = (byte_n + 4'd1 >= nbytes) ? i2cram_pkg::PH_MNACK
                                                           : i2cram_pkg::PH_MACK;
                    end
                end
                i2cram_pkg::PH_MACK:
                begin
                    if (slot_n == 2'd0)
                    begin
                        scl_q = 1'b0; sda_q = 1'b0; slot_n = 2'd1;
                    end
                    else if (slot_n == 2'd1)
                    begin
                        scl_q = 1'b1; sda_q = 1'b0; slot_n = 2'd2;
                    end
                    else if (slot_n == 2'd2)
                    begin
                        scl_q = 1'b0; sda_q = 1'b0; slot_n = 2'd3;
                    end
                    else
                    begin
                        scl_q = 1'b0; sda_q = 1'b1;
                        byte_n = byte_n + 4'd1;
                        bit_n = 3'd0; shifter = 8'd0; slot_n = 2'd0;
                        ph = i2cram_pkg::PH_READ;
                    end
                end
                i2cram_pkg::PH_MNACK:
                begin
                    sda_q = 1'b1;
                    if (slot_n == 2'd0)
                    begin
                        scl_q = 1'b0; slot_n = 2'd1;
                    end
                    else if (slot_n == 2'd1)
                    begin
                        scl_q = 1'b1; slot_n = 2'd2;
                    end
                    else
                    begin
                        scl_q = 1'b0;
                        stop_with(1'b0);
                    end
                end
                i2cram_pkg::PH_STOP:
                begin
                    // first stop slot keeps scl where it was
                    if (slot_n == 2'd0)
                    begin
                        sda_q = 1'b0; slot_n = 2'd1;
                    end
                    else if (slot_n == 2'd1)
                    begin
                        scl_q = 1'b1; sda_q = 1'b0; slot_n = 2'd2;
                    end
                    else
                    begin
                        scl_q = 1'b1; sda_q = 1'b1;
                        r.done = 1'b1; r.aerr = err_pend;
                        err_pend = 1'b0; slot_n = 2'd0;
                        ph = i2cram_pkg::PH_IDLE;
                    end
                end
                default:
                    ph = i2cram_pkg::PH_IDLE;
            endcase
        end
        r.scl = scl_q;
        r.sda = sda_q;
        r.busy = (ph != i2cram_pkg::PH_IDLE);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bus_slot_t got;
        bus_slot_t want;
        if (!rst_n)
        begin
            dev_addr = i2cram_pkg::DEV_ADDR_RESET;
            poll_limit = i2cram_pkg::POLL_LIMIT_RESET;
            ph = i2cram_pkg::PH_IDLE;
            stg = i2cram_pkg::ST_DEV;
            slot_n = 2'd0;
            bit_n = 3'd0;
            byte_n = 4'd0;
            shifter = 8'd0;
            wbuf = 64'd0;
            nbytes = 4'd1;
            polls = 10'd0;
            rd_op = 1'b0;
            reg_latch = 16'd0;
            err_pend = 1'b0;
            scl_q = 1'b1;
            sda_q = 1'b1;
            due_slots.delete();
            bad_beats = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == i2cram_pkg::CFG_DEV_ADDR)
                    dev_addr = cfg_data[7:0];
                else
                    poll_limit = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                got = {scl, sda_out, busy_res, read_valid, read_byte, done_res, ack_error};
                if (due_slots.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("%0t: result beat with nothing expected", $realtime);
                end
                else
                begin
                    want = due_slots.pop_front();
                    if (got !== want)
                    begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display({"%0t: expected scl=%b sda=%b busy=%b rv=%b rbyte=%h ",
                                      "done=%b err=%b, got scl=%b sda=%b busy=%b rv=%b ",
                                      "rbyte=%h done=%b err=%b"}, $realtime,
                                     want.scl, want.sda, want.busy, want.rvalid, want.rbyte,
                                     want.done, want.aerr, got.scl, got.sda, got.busy,
                                     got.rvalid, got.rbyte, got.done, got.aerr);
                    end
                end
            end
            if (in_valid && !in_stall)
                due_slots.push_back(predict_slot(kind, reg_addr, byte_count, write_data, sda_in));
        end
        mismatches <= bad_beats;
        pending <= due_slots.size();
    end

endmodule

// ===== bench/i2c_register_access_master_core_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the i2c register access master: drives register transfers
// tick by tick and gives the verdict; depends on i2cram_pkg and the checker
module i2c_register_access_master_core_tb;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [9:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [15:0] reg_addr;
    logic [3:0]  byte_count;
    logic [63:0] write_data;
    logic        sda_in;
    logic        out_valid;
    logic        out_stall;
    logic        scl;
    logic        sda_out;
    logic        busy_res;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        done_res;
    logic        ack_error;

    int mismatches;
    int pending;
    // beats that belong to a transfer, counted toward the random budget
    int items = 0;
    // stop slots seen on the result side; tells the sender a transfer is over
    int done_seen = 0;

    i2c_register_access_master_core dut
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .reg_addr(reg_addr),
        .byte_count(byte_count), .write_data(write_data), .sda_in(sda_in),
        .out_valid(out_valid), .out_stall(out_stall), .scl(scl), .sda_out(sda_out),
        .busy_res(busy_res), .read_valid(read_valid), .read_byte(read_byte),
        .done_res(done_res), .ack_error(ack_error)
    );

    i2c_register_access_master_core_checker checker_i
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .reg_addr(reg_addr),
        .byte_count(byte_count), .write_data(write_data), .sda_in(sda_in),
        .out_valid(out_valid), .out_stall(out_stall), .scl(scl), .sda_out(sda_out),
        .busy_res(busy_res), .read_valid(read_valid), .read_byte(read_byte),
        .done_res(done_res), .ack_error(ack_error),
        .mismatches(mismatches), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall && done_res)
            done_seen <= done_seen + 1;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one beat and hold it until taken; valid only drops for a real gap
    task automatic send_beat(input i2cram_pkg::kind_t k, input logic [15:0] ra,
        input logic [3:0] bc, input logic [63:0] wd, input logic sd, input bit gaps_on);
        int gap;
        in_valid <= 1'b1;
        kind <= k;
        reg_addr <= ra;
        byte_count <= bc;
        write_data <= wd;
        sda_in <= sd;
        do
            @(posedge clk);
        while (in_stall);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender pause until the checker has no result beat left pending
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input i2cram_pkg::cfg_index_t idx, input logic [9:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // one register transfer: the command beat, then tick beats until the stop
    // slot shows up on the result side. low_pct is the chance that a tick
    // samples sda low, which acks a poll and feeds zeros into a read byte
    task automatic run_transfer(input i2cram_pkg::kind_t k, input logic [15:0] ra,
        input logic [3:0] bc, input logic [63:0] wd, input int low_pct, input bit gaps_on);
        int target;
        int n;
        i2cram_pkg::kind_t tk;
        target = done_seen + 1;
        send_beat(k, ra, bc, wd, 1'($urandom_range(1)), gaps_on);
        items++;
        n = 0;
        while (done_seen < target)
        begin
            // a command early in the transfer lands while busy and must be dropped;
            // no transfer ends within its first dozen ticks, so this stays safe
            if (n < 12 && $urandom_range(5) == 0)
                send_beat($urandom_range(1) ? i2cram_pkg::KIND_READ : i2cram_pkg::KIND_WRITE,
                          16'($urandom), 4'($urandom), {$urandom, $urandom},
                          1'($urandom_range(1)), gaps_on);
            else
            begin
                // spare kind behaves as a tick
                tk = ($urandom_range(9) == 0) ? i2cram_pkg::KIND_SPARE : i2cram_pkg::KIND_TICK;
                send_beat(tk, 16'($urandom), 4'($urandom), {$urandom, $urandom},
                          ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1, gaps_on);
                items++;
            end
            n++;
        end
    endtask

    // random transfers until the budget is spent; mostly short byte counts so
    // that many transfers fit, a few full and out-of-range counts
    task automatic random_phase(input int budget);
        int stop_at;
        int r;
        int pct;
        logic [3:0] bc;
        stop_at = items + budget;
        while (items < stop_at)
        begin
            if ($urandom_range(7) == 0)
                settle();
            r = $urandom_range(9);
            if (r < 7)
                bc = 4'($urandom_range(1, 2));
            else if (r < 9)
                bc = 4'($urandom_range(3, 8));
            else
                bc = 4'($urandom_range(0, 15));
            r = $urandom_range(2);
            pct = (r == 0) ? 40 : (r == 1) ? 75 : 95;
            run_transfer($urandom_range(1) ? i2cram_pkg::KIND_READ : i2cram_pkg::KIND_WRITE,
                         16'($urandom), bc, {$urandom, $urandom}, pct,
                         $urandom_range(3) != 0);
        end
        settle();
    endtask

    // result side: random stalls after taken beats, quiet stretches, and one
    // long hold-off so the result register fills and the input side stalls
    initial
    begin
        int taken;
        int g;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                taken++;
                if (taken % 64 == 0)
                    quiet = ($urandom_range(3) == 0);
                g = (taken == 400) ? 300 : quiet ? 0 : pick_gap();
                if (g > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (g) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= i2cram_pkg::CFG_DEV_ADDR;
        cfg_data <= 10'd0;
        in_valid <= 1'b0;
        kind <= i2cram_pkg::KIND_TICK;
        reg_addr <= 16'd0;
        byte_count <= 4'd0;
        write_data <= 64'd0;
        sda_in <= 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: ticks while idle, field extremes, timeout
        send_beat(i2cram_pkg::KIND_TICK, 16'h0000, 4'h0, 64'h0, 1'b0, 1'b0);
        send_beat(i2cram_pkg::KIND_SPARE, 16'hffff, 4'hf, '1, 1'b1, 1'b0);
        // byte count zero acts as one
        run_transfer(i2cram_pkg::KIND_WRITE, 16'h0000, 4'd0, 64'h0, 100, 1'b0);
        // count above eight saturates, read bits random
        run_transfer(i2cram_pkg::KIND_READ, 16'hffff, 4'd15, 64'h0, 50, 1'b1);
        run_transfer(i2cram_pkg::KIND_WRITE, 16'hffff, 4'd8, '1, 100, 1'b1);
        // device never acks: poll runs out and the stop flags an error
        run_transfer(i2cram_pkg::KIND_READ, 16'h0000, 4'd1, 64'h0, 0, 1'b0);
        random_phase(50);

        // lowest address and a zero poll limit: first high sample times out
        write_reg(i2cram_pkg::CFG_DEV_ADDR, 10'h000);
        write_reg(i2cram_pkg::CFG_POLL_LIMIT, 10'd0);
        run_transfer(i2cram_pkg::KIND_WRITE, 16'h00ff, 4'd2, {$urandom, $urandom}, 0, 1'b0);
        random_phase(50);

        // all-ones address byte and the largest poll limit
        write_reg(i2cram_pkg::CFG_DEV_ADDR, 10'h3ff);
        write_reg(i2cram_pkg::CFG_POLL_LIMIT, 10'h3ff);
        random_phase(50);

        // short limits so high samples end transfers often
        write_reg(i2cram_pkg::CFG_DEV_ADDR, 10'($urandom));
        write_reg(i2cram_pkg::CFG_POLL_LIMIT, 10'($urandom_range(1, 6)));
        random_phase(50);

        write_reg(i2cram_pkg::CFG_DEV_ADDR, 10'($urandom));
        write_reg(i2cram_pkg::CFG_POLL_LIMIT, 10'($urandom));
        random_phase(50);

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
src/i2cram_pkg.sv
src/i2c_register_access_master_core.sv
bench/i2c_register_access_master_core_checker.sv
bench/i2c_register_access_master_core_tb.sv
